/* design/signed_int_to_decimal_chars_unit_defines.svh */
// assertion macros shared by the signed integer to decimal text unit
// uses clk and rst_n of the module that expands them; no other dependencies
`ifndef SIGNED_INT_TO_DECIMAL_CHARS_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_CHARS_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SIDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SIDC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SIDC_ASSERT(label, prop, msg)
`define SIDC_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* design/sidc_pkg.sv */
// constants, types and the digit split function of the decimal text unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sidc_pkg;

    localparam int VALUE_W    = 16;
    localparam int MAG_W      = 17;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 7;
    localparam int NUM_DIGITS = 5;
    localparam int NUM_CHARS  = 6;
    localparam int CNT_W      = 3;
    localparam int IDX_W      = 3;
    localparam int OUT_W      = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

    // divisors of the four leading digits; the last digit is the remainder
    localparam int unsigned DIVISORS [NUM_DIGITS-1] = '{10000, 1000, 100, 10};

    typedef struct packed {
        logic                                neg;
        logic [MAG_W-1:0]                    rem;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digs;
    } stage_t;

    typedef struct packed {
        logic [NUM_CHARS-1:0][CHAR_W-1:0] chars;
        logic [CNT_W-1:0]                 count;
    } item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [MAG_W-1:0]   rem;
    } split_t;

    // one decimal digit by parallel compares against the nine multiples
    function automatic split_t digit_of(logic [MAG_W-1:0] mag, int unsigned dv);
        split_t           res;
        logic [MAG_W-1:0] sub;
        sub       = '0;
        res.digit = '0;
        for (int m = 1; m <= 9; m++)
        begin
            if (mag >= MAG_W'(m * dv))
            begin
                res.digit = DIGIT_W'(m);
                sub       = MAG_W'(m * dv);
            end
        end
        res.rem = mag - sub;
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/sidc_serializer.sv */
// character serializer: holds one packed number and sends its characters in order
// depends on sidc_pkg and signed_int_to_decimal_chars_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_decimal_chars_unit_defines.svh"

module sidc_serializer
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire sidc_pkg::item_t               in_item,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sidc_pkg::OUT_W-1:0]         m_tdata,   // [6:0] character, [7] zero
    output logic                               m_tlast    // last character of the number
);

    sidc_pkg::item_t                 item_reg;
    logic [sidc_pkg::IDX_W-1:0]      idx_reg;
    logic [sidc_pkg::IDX_W-1:0]      idx_next;
    logic                            valid_reg;
    logic                            is_last;
    logic                            take;

    assign idx_next = idx_reg + sidc_pkg::IDX_W'(1);
    assign is_last  = (idx_next == item_reg.count);
    assign take     = valid_reg && m_tready;
    assign in_ready = !valid_reg || (m_tready && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_next;
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, item_reg.chars[idx_reg]};
    assign m_tlast  = valid_reg && is_last;

    `SIDC_ASSERT(a_count_range,
        valid_reg |-> (item_reg.count != '0
                       && item_reg.count <= sidc_pkg::CNT_W'(sidc_pkg::NUM_CHARS)),
        "character count out of range")
    `SIDC_ASSERT(a_idx_below_count,
        valid_reg |-> (idx_reg < item_reg.count),
        "character index past count")
    `SIDC_ASSERT(a_drop_after_last,
        (take && is_last && !in_valid) |=> !valid_reg,
        "number not retired after last character")

endmodule

`default_nettype wire

/* design/signed_int_to_decimal_chars_unit.sv */
// channel  dir  tdata                     tuser  tlast
// s_       in   [15:0] value (signed)     -      -
// m_       out  [6:0] character, [7] 0    -      last character of the number
//
// one number comes out as 1 to 6 characters, one per output transfer, sent in order
// by the single character serializer at the output; rst_n clears the valid bits
// and the serializer's character index only; a number passes six register stages
// (magnitude, four digit stages, packing) and the serializer's item register before
// its first character shows; stalls back up stage by stage, nothing is lost
// depends on sidc_pkg, sidc_serializer and signed_int_to_decimal_chars_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_decimal_chars_unit_defines.svh"

module signed_int_to_decimal_chars_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sidc_pkg::VALUE_W-1:0]      s_tdata,   // [15:0] value
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [sidc_pkg::OUT_W-1:0]             m_tdata,   // [6:0] character, [7] zero
    output logic                                   m_tlast
);

    localparam int NST = sidc_pkg::NUM_DIGITS;   // magnitude stage plus four digit stages

    logic [NST:0]          v_reg;
    logic [NST:0]          en;
    sidc_pkg::stage_t      st_reg  [NST];
    sidc_pkg::stage_t      st_next [NST];
    sidc_pkg::item_t       item_reg;
    sidc_pkg::item_t       item_next;
    logic                  ser_ready;
    logic [sidc_pkg::MAG_W-1:0] raw_ext;

    // a stage moves when empty or when the one after it moves
    always_comb
    begin
        en[NST] = !v_reg[NST] || ser_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign raw_ext  = {1'b0, s_tdata};

    // magnitude stage, then one decimal digit per stage
    always_comb
    begin
        sidc_pkg::split_t sp;
        st_next[0]      = '0;
        st_next[0].neg  = s_tdata[sidc_pkg::VALUE_W-1];
        st_next[0].rem  = s_tdata[sidc_pkg::VALUE_W-1]
                        ? (sidc_pkg::MAG_W'(17'h10000) - raw_ext) : raw_ext;
        for (int k = 1; k < NST; k++)
        begin
            sp                   = sidc_pkg::digit_of(st_reg[k-1].rem, sidc_pkg::DIVISORS[k-1]);
            st_next[k]           = st_reg[k-1];
            st_next[k].digs[k-1] = sp.digit;
            st_next[k].rem       = sp.rem;
        end
    end

    // packing: suppress leading zeros, put the sign in front
    always_comb
    begin
        logic [sidc_pkg::NUM_DIGITS-1:0][sidc_pkg::DIGIT_W-1:0] d;
        logic [2:0] off;
        logic [3:0] src;
        logic       neg;
        d                        = st_reg[NST-1].digs;
        d[sidc_pkg::NUM_DIGITS-1] = st_reg[NST-1].rem[sidc_pkg::DIGIT_W-1:0];
        neg                      = st_reg[NST-1].neg;
        if (d[0] != '0)
            off = 3'd0;
        else if (d[1] != '0)
            off = 3'd1;
        else if (d[2] != '0)
            off = 3'd2;
        else if (d[3] != '0)
            off = 3'd3;
        else
            off = 3'd4;
        item_next.count = sidc_pkg::CNT_W'(3'd5 - off + {2'b0, neg});
        for (int k = 0; k < sidc_pkg::NUM_CHARS; k++)
        begin
            src = 4'(k) + {1'b0, off} - {3'b0, neg};
            if (neg && k == 0)
                item_next.chars[k] = sidc_pkg::CHAR_MINUS;
            else if (src < 4'(sidc_pkg::NUM_DIGITS))
                item_next.chars[k] = sidc_pkg::CHAR_ZERO + {3'b0, d[src[2:0]]};
            else
                item_next.chars[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k <= NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (en[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
        if (en[NST])
        begin
            item_reg <= item_next;
        end
    end

    sidc_serializer u_ser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v_reg[NST]),
        .in_ready (ser_ready),
        .in_item  (item_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `SIDC_ASSERT(a_hold_when_stalled,
        (v_reg[NST] && !ser_ready) |=> v_reg[NST],
        "packed number dropped while stalled")
    `SIDC_ASSERT(a_mag_range,
        v_reg[0] |-> (st_reg[0].rem <= sidc_pkg::MAG_W'(17'h10000)),
        "magnitude out of range")
    `SIDC_ASSERT(a_last_rem_digit,
        v_reg[NST-1] |-> (st_reg[NST-1].rem < sidc_pkg::MAG_W'(10)),
        "remainder not a single digit")

endmodule

`default_nettype wire

/* tb/tb_signed_int_to_decimal_chars_unit.sv */
// testbench of signed_int_to_decimal_chars_unit: signed 16-bit values in, decimal ascii text out
// directed and random values under changing idle and stall patterns, checked by a scoreboard
// depends on sidc_pkg and the unit itself
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_chars_unit;

    import sidc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    class char_scoreboard;

        typedef struct
        {
            logic [CHAR_W-1:0] character;
            logic              last;
        } char_exp_t;

        char_exp_t expected_chars[$];
        int        mismatches = 0;

        // decimal text of one accepted value, most significant character first
        function void note_value(logic [VALUE_W-1:0] value);
            int unsigned       divisor_list[5] = '{10000, 1000, 100, 10, 1};
            logic [MAG_W-1:0]  magnitude;
            int unsigned       digit;
            bit                started;
            logic [CHAR_W-1:0] text[$];
            char_exp_t         entry;
            started = 1'b0;
            if (value[VALUE_W-1])
            begin
                magnitude = MAG_W'(17'h10000 - {1'b0, value});
                text.push_back(CHAR_MINUS);
            end
            else
            begin
                magnitude = {1'b0, value};
            end
            for (int i = 0; i < 5; i++)
            begin
                digit     = magnitude / divisor_list[i];
                magnitude = MAG_W'(magnitude - digit * divisor_list[i]);
                // leading zeros dropped, but zero itself still shows one digit
                if (digit == 0 && !started && i < 4)
                    continue;
                started = 1'b1;
                text.push_back(CHAR_ZERO + CHAR_W'(digit));
            end
            foreach (text[i])
            begin
                entry.character = text[i];
                entry.last      = (i == text.size() - 1);
                expected_chars.push_back(entry);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] character, logic last);
            char_exp_t entry;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected character %0d last %0b", $time, character, last);
                return;
            end
            entry = expected_chars.pop_front();
            if (character !== entry.character || last !== entry.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: got character %0d last %0b, expected character %0d last %0b",
                             $time, character, last, entry.character, entry.last);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;

    char_scoreboard sb;
    int             idle_pct  = 0;
    int             stall_pct = 0;
    int             cycles    = 0;

    signed_int_to_decimal_chars_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99, 0) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_char(m_tdata[CHAR_W-1:0], m_tlast);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // called just after a falling edge, returns just after a falling edge once the value has been accepted
    task automatic send_value(input logic [VALUE_W-1:0] value);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= VALUE_W'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_value(value);
        @(negedge clk);
    endtask

    // hold off the sender until every character in flight has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // mostly values of a chosen digit count, so every text length shows up often
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned pow10[6] = '{1, 10, 100, 1000, 10000, 100000};
        int unsigned ndigits;
        int unsigned lo;
        int unsigned hi;
        int unsigned magnitude;
        ndigits = $urandom_range(5, 0);
        if (ndigits == 0)
            return VALUE_W'($urandom);
        lo = (ndigits == 1) ? 0 : pow10[ndigits-1];
        hi = pow10[ndigits] - 1;
        if (hi > 32767)
            hi = 32767;
        magnitude = $urandom_range(hi, lo);
        if ($urandom_range(1, 0) == 1)
        begin
            if (ndigits == 5 && $urandom_range(7, 0) == 0)
                magnitude = 32768;
            return VALUE_W'(0 - magnitude);
        end
        return VALUE_W'(magnitude);
    endfunction

    initial
    begin
        int directed_values[25];
        int phase_idle[4];
        int phase_stall[4];
        directed_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -999, 1000, 9999,
                            10000, -10000, 10001, 32767, -32768, -32767, 12345,
                            -23456, 20000, 7, 30909, -1000, 505};
        phase_idle      = '{0, 56, 0, 7};
        phase_stall     = '{0, 0, 56, 7};
        sb = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_values[i])
            send_value(VALUE_W'(directed_values[i]));
        drain();

        for (int round = 0; round < 2; round++)
        begin
            for (int p = 0; p < 4; p++)
            begin
                idle_pct  = phase_idle[p];
                stall_pct = phase_stall[p];
                repeat (31) send_value(random_value());
                drain();
            end
        end

        // anything extra coming out late still gets caught
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d characters never arrived", $time, sb.pending());

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
